>>> design/modbus_tcp_register_server_unit_macros.svh
// Assertion macros shared by the Modbus TCP register server RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef MODBUS_TCP_REGISTER_SERVER_UNIT_MACROS_SVH
`define MODBUS_TCP_REGISTER_SERVER_UNIT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define MBTCP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define MBTCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mbtcp_pkg.sv
// Shared constants, codes and types of the Modbus TCP register server.
// No dependencies; used by the interfaces' users, front, queue, back and top.
package mbtcp_pkg;

    localparam int NUM_REGS     = 256;
    localparam int MAX_READ_QTY = 27;
    localparam int FRAME_LIMIT  = 256;
    localparam int HEAD_LEN     = 12;
    localparam int MBAP_LEN     = 7;
    localparam int MIN_FRAME    = MBAP_LEN + 2;
    localparam int PDU_MIN      = 2;
    localparam int PDU_MIN_REG  = 5;
    localparam int QUEUE_DEPTH  = 4;

    localparam int REG_AW     = $clog2(NUM_REGS);
    localparam int CNT_W      = $clog2(FRAME_LIMIT + 1);
    localparam int CFG_W      = 9;
    localparam int MAX_REPLY  = MBAP_LEN + 2 + 2 * MAX_READ_QTY;
    localparam int BYTE_IDX_W = $clog2(MAX_REPLY);
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_W-1:0] REGS_RESET = CFG_W'(256);
    localparam logic             REG_IDX_REGS_IN_USE = 1'b0;

    localparam logic [7:0]  FC_READ_HOLDING  = 8'h03;
    localparam logic [7:0]  FC_WRITE_SINGLE  = 8'h06;
    localparam logic [7:0]  EXC_FLAG         = 8'h80;
    localparam logic [7:0]  EXC_ILLEGAL_ADDR = 8'h02;
    localparam logic [7:0]  EXC_ILLEGAL_FUNC = 8'h01;
    localparam logic [15:0] PROTO_MODBUS     = 16'h0000;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_LOCAL = 1'b1;

    typedef enum logic [1:0] {
        CMD_RX_BYTE     = 2'd0,
        CMD_LOCAL_WRITE = 2'd1,
        CMD_LOCAL_READ  = 2'd2,
        CMD_NONE        = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        JOB_RD_REPLY  = 3'd0,
        JOB_WR_REPLY  = 3'd1,
        JOB_EXC_REPLY = 3'd2,
        JOB_LOC_WRITE = 3'd3,
        JOB_LOC_READ  = 3'd4
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] tid;
        logic [7:0]  unit_id;
        logic [7:0]  func;
        logic [7:0]  exc_code;
        logic [15:0] addr;
        logic [15:0] value;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> design/mbtcp_if.sv
// Valid/ready channel interfaces of the Modbus TCP register server.
// Request channel carries frame bytes and local commands; response carries reply items.
interface mbtcp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic [7:0]  local_addr;
    logic [15:0] local_value;

    modport source (
        output valid, cmd, rx_byte, frame_end, local_addr, local_value,
        input  ready
    );
    modport sink (
        input  valid, cmd, rx_byte, frame_end, local_addr, local_value,
        output ready
    );
endinterface

interface mbtcp_rsp_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] read_value;

    modport source (
        output valid, kind, tx_byte, tx_last, read_value,
        input  ready
    );
    modport sink (
        input  valid, kind, tx_byte, tx_last, read_value,
        output ready
    );
endinterface

>>> design/modbus_tcp_register_server_unit.sv
// Top level of the Modbus TCP register server: APB register, front, job queue, back.
// Depends on mbtcp_pkg, mbtcp_if, mbtcp_front, mbtcp_queue and mbtcp_back.
//
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    cmd, rx_byte, frame_end, local_addr, local_value
// rsp      out  valid/ready    kind, tx_byte, tx_last, read_value
// apb      in   psel/penable   paddr, pwdata, prdata; regs_in_use at offset 0x0
//
// The front takes one request item per cycle while the 4-entry job queue has room.
// The back runs one job at a time on the single store port: a local write in IDLE,
// a local read via IDLE and LOUT, a reply via SEND at one byte per cycle unless rsp stalls.
// Reset clears the store's per-entry valid bits, so the store reads zero at once.
// rsp.ready low holds the output register and the back; a full queue holds req.
module modbus_tcp_register_server_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    mbtcp_req_if.sink                             req,
    mbtcp_rsp_if.source                           rsp,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mbtcp_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import mbtcp_pkg::*;

    logic [CFG_W-1:0] regs_in_use_reg;
    logic             reg_idx;
    job_push_t        push;
    job_t             q_head;
    queue_status_t    q_status;
    logic             q_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1];
    assign prdata  = (reg_idx == REG_IDX_REGS_IN_USE) ? 32'(regs_in_use_reg) : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_in_use_reg <= REGS_RESET;
        end
        else if (psel && penable && pwrite && pready && (reg_idx == REG_IDX_REGS_IN_USE))
        begin
            regs_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    mbtcp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .regs_in_use (regs_in_use_reg),
        .q_status    (q_status),
        .push        (push)
    );

    mbtcp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (q_pop),
        .head   (q_head),
        .status (q_status)
    );

    mbtcp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_status (q_status),
        .pop      (q_pop),
        .rsp      (rsp)
    );

endmodule

>>> design/mbtcp_front.sv
// Front end: takes request items, collects the frame head and classifies frames into jobs.
// Depends on mbtcp_pkg and mbtcp_req_if.
module mbtcp_front (
    input  logic                           clk,
    input  logic                           rst_n,
    mbtcp_req_if.sink                      req,
    input  logic [mbtcp_pkg::CFG_W-1:0]    regs_in_use,
    input  mbtcp_pkg::queue_status_t       q_status,
    output mbtcp_pkg::job_push_t           push
);
    import mbtcp_pkg::*;

    logic [7:0]       head_reg  [HEAD_LEN];
    logic [7:0]       head_next [HEAD_LEN];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_cur;
    logic             accept;
    logic             rx_take;
    cmd_t             cmd;
    logic [15:0]      proto;
    logic [15:0]      length;
    logic [15:0]      pdu_len;
    logic [15:0]      start_addr;
    logic [15:0]      quantity;
    logic [7:0]       func;
    logic [CFG_W-1:0] total;
    logic             frame_ok;
    logic             read_bad;
    logic             write_bad;
    logic             want;
    job_t             job;

    assign cmd       = cmd_t'(req.cmd);
    assign req.ready = !q_status.full;
    assign accept    = req.valid && req.ready;
    assign rx_take   = accept && (cmd == CMD_RX_BYTE) && (count_reg < CNT_W'(FRAME_LIMIT));
    assign count_cur = (count_reg < CNT_W'(FRAME_LIMIT)) ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        for (int j = 0; j < HEAD_LEN; j++)
        begin
            head_next[j] = head_reg[j];
            if (rx_take && (count_reg == CNT_W'(j)))
            begin
                head_next[j] = req.rx_byte;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept && (cmd == CMD_RX_BYTE))
        begin
            count_next = req.frame_end ? '0 : count_cur;
        end
    end

    assign proto      = {head_next[2], head_next[3]};
    assign length     = {head_next[4], head_next[5]};
    assign pdu_len    = length - 16'd1;
    assign func       = head_next[MBAP_LEN];
    assign start_addr = {head_next[8], head_next[9]};
    assign quantity   = {head_next[10], head_next[11]};
    assign total      = (regs_in_use > CFG_W'(NUM_REGS)) ? CFG_W'(NUM_REGS) : regs_in_use;

    assign frame_ok = (count_cur >= CNT_W'(MIN_FRAME))
                   && (proto == PROTO_MODBUS)
                   && (length != 16'd0)
                   && (length <= 16'(count_cur - CNT_W'(6)));

    assign read_bad  = (quantity > 16'(MAX_READ_QTY))
                    || ((17'(start_addr) + 17'(quantity)) > 17'(total));
    assign write_bad = start_addr >= 16'(total);

    always_comb
    begin
        want         = 1'b0;
        job.kind     = JOB_EXC_REPLY;
        job.tid      = {head_next[0], head_next[1]};
        job.unit_id  = head_next[6];
        job.func     = func;
        job.exc_code = EXC_ILLEGAL_FUNC;
        job.addr     = start_addr;
        job.value    = quantity;
        unique case (cmd)
            CMD_RX_BYTE:
            begin
                if (req.frame_end && frame_ok && (pdu_len >= 16'(PDU_MIN)))
                begin
                    if (func == FC_READ_HOLDING)
                    begin
                        want         = pdu_len >= 16'(PDU_MIN_REG);
                        job.kind     = read_bad ? JOB_EXC_REPLY : JOB_RD_REPLY;
                        job.exc_code = EXC_ILLEGAL_ADDR;
                    end
                    else if (func == FC_WRITE_SINGLE)
                    begin
                        want         = pdu_len >= 16'(PDU_MIN_REG);
                        job.kind     = write_bad ? JOB_EXC_REPLY : JOB_WR_REPLY;
                        job.exc_code = EXC_ILLEGAL_ADDR;
                    end
                    else
                    begin
                        want = 1'b1;
                    end
                end
            end
            CMD_LOCAL_WRITE:
            begin
                want      = 1'b1;
                job.kind  = JOB_LOC_WRITE;
                job.addr  = 16'(req.local_addr);
                job.value = req.local_value;
            end
            CMD_LOCAL_READ:
            begin
                want     = 1'b1;
                job.kind = JOB_LOC_READ;
                job.addr = 16'(req.local_addr);
            end
            CMD_NONE:
            begin
                want = 1'b0;
            end
            default:
            begin
                want = 1'b0;
            end
        endcase
    end

    assign push.valid = accept && want;
    assign push.job   = job;

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

>>> design/mbtcp_queue.sv
// Job queue between front and back: a small register FIFO of classified jobs.
// Depends on mbtcp_pkg and the assertion macro header.
`include "modbus_tcp_register_server_unit_macros.svh"

module mbtcp_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mbtcp_pkg::job_push_t      push,
    input  logic                      pop,
    output mbtcp_pkg::job_t           head,
    output mbtcp_pkg::queue_status_t  status
);
    import mbtcp_pkg::*;

    localparam int QP_W = $clog2(QUEUE_DEPTH);

    job_t            ent_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg;
    logic [QP_W-1:0] rd_ptr_reg;
    logic [QP_W:0]   cnt_reg;
    logic [QP_W:0]   cnt_next;

    assign head         = ent_reg[rd_ptr_reg];
    assign status.full  = cnt_reg == (QP_W + 1)'(QUEUE_DEPTH);
    assign status.empty = cnt_reg == '0;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push.valid && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            ent_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    `MBTCP_ASSERT_ALWAYS(a_no_push_full, !(push.valid && status.full), "job pushed into full queue")
    `MBTCP_ASSERT_ALWAYS(a_no_pop_empty, !(pop && status.empty), "job popped from empty queue")
    `MBTCP_ASSERT_NEXT(a_fill_tracks, push.valid && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "queue fill did not advance")

endmodule

>>> design/mbtcp_back.sv
// Back end: runs jobs against the holding-register store and sends reply items.
// Depends on mbtcp_pkg, mbtcp_rsp_if and the assertion macro header.
`include "modbus_tcp_register_server_unit_macros.svh"

module mbtcp_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mbtcp_pkg::job_t           head,
    input  mbtcp_pkg::queue_status_t  q_status,
    output logic                      pop,
    mbtcp_rsp_if.source               rsp
);
    import mbtcp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SEND = 3'b010,
        S_LOUT = 3'b100
    } state_t;

    localparam logic [BYTE_IDX_W-1:0] POS_TID_HI   = BYTE_IDX_W'(0);
    localparam logic [BYTE_IDX_W-1:0] POS_TID_LO   = BYTE_IDX_W'(1);
    localparam logic [BYTE_IDX_W-1:0] POS_PROTO_HI = BYTE_IDX_W'(2);
    localparam logic [BYTE_IDX_W-1:0] POS_PROTO_LO = BYTE_IDX_W'(3);
    localparam logic [BYTE_IDX_W-1:0] POS_LEN_HI   = BYTE_IDX_W'(4);
    localparam logic [BYTE_IDX_W-1:0] POS_LEN_LO   = BYTE_IDX_W'(5);
    localparam logic [BYTE_IDX_W-1:0] POS_UNIT     = BYTE_IDX_W'(6);
    localparam logic [BYTE_IDX_W-1:0] POS_FUNC     = BYTE_IDX_W'(MBAP_LEN);
    localparam logic [BYTE_IDX_W-1:0] POS_PDU1     = BYTE_IDX_W'(MBAP_LEN + 1);
    localparam logic [BYTE_IDX_W-1:0] POS_PDU2     = BYTE_IDX_W'(MBAP_LEN + 2);
    localparam logic [BYTE_IDX_W-1:0] POS_PDU3     = BYTE_IDX_W'(MBAP_LEN + 3);
    localparam logic [BYTE_IDX_W-1:0] POS_PDU4     = BYTE_IDX_W'(MBAP_LEN + 4);

    state_t                state_reg;
    state_t                state_next;
    job_t                  job_reg;
    logic [BYTE_IDX_W-1:0] k_reg;
    logic [BYTE_IDX_W-1:0] k_next;
    logic [BYTE_IDX_W-1:0] last_reg;
    logic [BYTE_IDX_W-1:0] last_next;
    logic [REG_AW-1:0]     rptr_reg;
    logic [REG_AW-1:0]     rptr_next;

    logic [15:0]           store_mem [NUM_REGS];
    logic [NUM_REGS-1:0]   vld_reg;
    logic [15:0]           rd_data_reg;
    logic                  rd_vld_reg;
    logic                  we;
    logic [REG_AW-1:0]     waddr;
    logic                  re;
    logic [REG_AW-1:0]     raddr;
    logic [15:0]           word;

    logic                  out_vld_reg;
    logic                  out_kind_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_last_reg;
    logic [15:0]           out_value_reg;
    logic                  out_free;
    logic [7:0]            tx_byte;
    logic [15:0]           reply_len;

    assign out_free       = !out_vld_reg || rsp.ready;
    assign rsp.valid      = out_vld_reg;
    assign rsp.kind       = out_kind_reg;
    assign rsp.tx_byte    = out_byte_reg;
    assign rsp.tx_last    = out_last_reg;
    assign rsp.read_value = out_value_reg;

    assign pop       = (state_reg == S_IDLE) && !q_status.empty;
    assign word      = rd_vld_reg ? rd_data_reg : 16'h0000;
    assign reply_len = 16'(last_reg) - 16'(MBAP_LEN - 2);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        last_next  = last_reg;
        rptr_next  = rptr_reg;
        we         = 1'b0;
        waddr      = head.addr[REG_AW-1:0];
        re         = 1'b0;
        raddr      = rptr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    k_next    = '0;
                    rptr_next = head.addr[REG_AW-1:0];
                    unique case (head.kind) inside
                        JOB_RD_REPLY:
                        begin
                            state_next = S_SEND;
                            last_next  = POS_PDU1 + BYTE_IDX_W'({head.value, 1'b0});
                        end
                        JOB_WR_REPLY:
                        begin
                            we         = 1'b1;
                            state_next = S_SEND;
                            last_next  = POS_PDU4;
                        end
                        JOB_EXC_REPLY:
                        begin
                            state_next = S_SEND;
                            last_next  = POS_PDU1;
                        end
                        JOB_LOC_WRITE:
                        begin
                            we = 1'b1;
                        end
                        JOB_LOC_READ:
                        begin
                            re         = 1'b1;
                            raddr      = head.addr[REG_AW-1:0];
                            state_next = S_LOUT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEND:
            begin
                if (out_free)
                begin
                    if ((job_reg.kind == JOB_RD_REPLY) && (k_reg >= POS_PDU1) && !k_reg[0])
                    begin
                        re        = 1'b1;
                        rptr_next = rptr_reg + 1'b1;
                    end
                    if (k_reg == last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            S_LOUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        tx_byte = 8'h00;
        case (k_reg) inside
            POS_TID_HI:                 tx_byte = job_reg.tid[15:8];
            POS_TID_LO:                 tx_byte = job_reg.tid[7:0];
            POS_PROTO_HI, POS_PROTO_LO: tx_byte = 8'h00;
            POS_LEN_HI:                 tx_byte = reply_len[15:8];
            POS_LEN_LO:                 tx_byte = reply_len[7:0];
            POS_UNIT:                   tx_byte = job_reg.unit_id;
            POS_FUNC:
            begin
                if (job_reg.kind == JOB_RD_REPLY)
                begin
                    tx_byte = FC_READ_HOLDING;
                end
                else if (job_reg.kind == JOB_WR_REPLY)
                begin
                    tx_byte = job_reg.func;
                end
                else
                begin
                    tx_byte = job_reg.func | EXC_FLAG;
                end
            end
            POS_PDU1:
            begin
                if (job_reg.kind == JOB_RD_REPLY)
                begin
                    tx_byte = {job_reg.value[6:0], 1'b0};
                end
                else if (job_reg.kind == JOB_WR_REPLY)
                begin
                    tx_byte = job_reg.addr[15:8];
                end
                else
                begin
                    tx_byte = job_reg.exc_code;
                end
            end
            default:
            begin
                if (job_reg.kind == JOB_RD_REPLY)
                begin
                    tx_byte = k_reg[0] ? word[15:8] : word[7:0];
                end
                else if (k_reg == POS_PDU2)
                begin
                    tx_byte = job_reg.addr[7:0];
                end
                else if (k_reg == POS_PDU3)
                begin
                    tx_byte = job_reg.value[15:8];
                end
                else
                begin
                    tx_byte = job_reg.value[7:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= head.value;
        end
        if (re)
        begin
            rd_data_reg <= store_mem[raddr];
            rd_vld_reg  <= vld_reg[raddr];
        end
        if (pop)
        begin
            job_reg <= head;
        end
    end

    always_ff @(posedge clk)
    begin
        if (((state_reg == S_SEND) || (state_reg == S_LOUT)) && out_free)
        begin
            out_kind_reg  <= (state_reg == S_LOUT) ? KIND_LOCAL : KIND_REPLY;
            out_byte_reg  <= (state_reg == S_LOUT) ? 8'h00 : tx_byte;
            out_last_reg  <= (state_reg == S_LOUT) ? 1'b1 : (k_reg == last_reg);
            out_value_reg <= (state_reg == S_LOUT) ? word : 16'h0000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            last_reg    <= '0;
            rptr_reg    <= '0;
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            last_reg  <= last_next;
            rptr_reg  <= rptr_next;
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (((state_reg == S_SEND) || (state_reg == S_LOUT)) && out_free)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    `MBTCP_ASSERT_ALWAYS(a_index_bound, (state_reg != S_SEND) || (k_reg <= last_reg), "reply index ran past last byte")
    `MBTCP_ASSERT_ALWAYS(a_port_single, !(we && re), "store written and read in one cycle")
    `MBTCP_ASSERT_NEXT(a_local_result, (state_reg == S_LOUT) && out_free, out_vld_reg && out_last_reg && (out_kind_reg == KIND_LOCAL), "local read result not loaded")

endmodule
